@@ rtl/wmbda_pkg.sv @@
// ----------------------------------------------------------------------------
// wmbda_pkg
// Shared types, codes and the CRC-16 byte update for the block CRC deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package wmbda_pkg;

  localparam int unsigned TotalW = 9;

  localparam logic [15:0] CrcPoly   = 16'h3D65;
  localparam logic [15:0] CrcInit   = 16'h0000;
  localparam logic [15:0] CrcXorOut = 16'hFFFF;

  typedef enum logic [2:0] {
    KIND_DATA      = 3'd0,
    KIND_COMPLETE  = 3'd1,
    KIND_EARLY     = 3'd2,
    KIND_ERR_FIRST = 3'd3,
    KIND_ERR_DATA  = 3'd4,
    KIND_TRUNC     = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    S_COLLECT,
    S_CRC_HI,
    S_CRC_LO,
    S_COMPLETE,
    S_ERR_FIRST,
    S_ERR_DATA,
    S_RELEASE,
    S_STATUS
  } ctrl_state_e;

  // controller -> datapath
  typedef struct packed {
    logic  store_byte;
    logic  latch_hi;
    logic  accept_block;
    logic  blk_clear;
    logic  frame_clear;
    logic  emit_data;
    logic  emit_status;
    kind_e status_kind;
  } dfr_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic blk_done;
    logic crc_ok;
    logic first_blk;
    logic total_done;
    logic last_rd;
    logic out_free;
  } dfr_sts_t;

  // msb-first crc-16 update over one byte
  function automatic logic [15:0] crc_add(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ rtl/wmbda_dp.sv @@
// ----------------------------------------------------------------------------
// wmbda_dp
// Block store, running CRC, byte counters and the output word register.
// ----------------------------------------------------------------------------
`default_nettype none

module wmbda_dp #(
  parameter int unsigned FIRST_BLOCK_LEN = 10,
  parameter int unsigned DATA_BLOCK_LEN  = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic [7:0]          rx_byte_i,
  input  wire wmbda_pkg::dfr_cmd_t cmd_i,
  output wmbda_pkg::dfr_sts_t      sts_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [7:0]               data_byte_o,
  output logic [2:0]               kind_o,
  output logic                     last_o
);
  import wmbda_pkg::*;

  localparam int unsigned StoreDepth =
    (FIRST_BLOCK_LEN > DATA_BLOCK_LEN) ? FIRST_BLOCK_LEN : DATA_BLOCK_LEN;
  localparam int unsigned AddrW = (StoreDepth > 1) ? $clog2(StoreDepth) : 1;
  localparam int unsigned FillW = $clog2(StoreDepth + 1);

  logic [7:0]        mem_q [StoreDepth];
  logic [7:0]        rd_data_q;
  logic [AddrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [FillW-1:0]  fill_q, fill_d;
  logic [15:0]       crc_q, crc_d;
  logic [7:0]        crc_hi_q, crc_hi_d;
  logic [TotalW-1:0] expected_q, expected_d;
  logic [TotalW-1:0] delivered_q, delivered_d;
  logic              out_valid_q, out_valid_d;
  logic [7:0]        out_data_q, out_data_d;
  kind_e             out_kind_q, out_kind_d;
  logic              out_last_q, out_last_d;

  logic [TotalW-1:0] remain;
  logic [TotalW-1:0] target;
  logic [TotalW-1:0] fill_next;
  logic              first_blk;
  logic              out_free;

  assign first_blk = (delivered_q == '0);
  assign remain    = (expected_q > delivered_q) ? (expected_q - delivered_q) : '0;
  assign fill_next = TotalW'(fill_q) + TotalW'(1);
  assign out_free  = !out_valid_q || out_ready_i;

  always_comb begin
    if (first_blk) begin
      target = TotalW'(FIRST_BLOCK_LEN);
    end else if (remain > TotalW'(DATA_BLOCK_LEN)) begin
      target = TotalW'(DATA_BLOCK_LEN);
    end else begin
      target = remain;
    end
  end

  always_comb begin
    sts_o.blk_done   = (fill_next >= target);
    sts_o.crc_ok     = ({crc_hi_q, rx_byte_i} == (crc_q ^ CrcXorOut));
    sts_o.first_blk  = first_blk;
    sts_o.total_done = (delivered_q >= expected_q);
    sts_o.last_rd    = ((FillW'(rd_ptr_q) + FillW'(1)) == fill_q);
    sts_o.out_free   = out_free;
  end

  always_comb begin
    fill_d      = fill_q;
    crc_d       = crc_q;
    crc_hi_d    = crc_hi_q;
    expected_d  = expected_q;
    delivered_d = delivered_q;
    rd_ptr_d    = rd_ptr_q;
    if (cmd_i.store_byte) begin
      fill_d = fill_q + FillW'(1);
      crc_d  = crc_add(crc_q, rx_byte_i);
    end
    if (cmd_i.latch_hi) begin
      crc_hi_d = rx_byte_i;
    end
    if (cmd_i.accept_block) begin
      delivered_d = delivered_q + TotalW'(fill_q);
      // read port sits on entry 0 here, which holds the length byte
      if (first_blk) begin
        expected_d = TotalW'(rd_data_q) + TotalW'(1);
      end
    end
    if (cmd_i.emit_data) begin
      rd_ptr_d = rd_ptr_q + AddrW'(1);
    end
    if (cmd_i.blk_clear) begin
      fill_d   = '0;
      crc_d    = CrcInit;
      rd_ptr_d = '0;
    end
    if (cmd_i.frame_clear) begin
      fill_d      = '0;
      crc_d       = CrcInit;
      crc_hi_d    = '0;
      expected_d  = '0;
      delivered_d = '0;
      rd_ptr_d    = '0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_kind_d  = out_kind_q;
    out_last_d  = out_last_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.emit_data) begin
      out_valid_d = 1'b1;
      out_data_d  = rd_data_q;
      out_kind_d  = KIND_DATA;
      out_last_d  = 1'b0;
    end else if (cmd_i.emit_status) begin
      out_valid_d = 1'b1;
      out_data_d  = '0;
      out_kind_d  = cmd_i.status_kind;
      out_last_d  = 1'b1;
    end
  end

  // block store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.store_byte) begin
      mem_q[fill_q[AddrW-1:0]] <= rx_byte_i;
    end
    rd_data_q <= mem_q[rd_ptr_d];
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    out_kind_q <= out_kind_d;
    out_last_q <= out_last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      crc_q       <= CrcInit;
      crc_hi_q    <= '0;
      expected_q  <= '0;
      delivered_q <= '0;
      rd_ptr_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      fill_q      <= fill_d;
      crc_q       <= crc_d;
      crc_hi_q    <= crc_hi_d;
      expected_q  <= expected_d;
      delivered_q <= delivered_d;
      rd_ptr_q    <= rd_ptr_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign data_byte_o = out_data_q;
  assign kind_o      = out_kind_q;
  assign last_o      = out_last_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(StoreDepth))
    else $error("block fill beyond store depth");

  a_emit_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit_data || cmd_i.emit_status) |-> out_free)
    else $error("word loaded into occupied output register");

  a_rd_in_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_data |-> (FillW'(rd_ptr_q) < fill_q))
    else $error("release reads past the block fill");

endmodule

`default_nettype wire

@@ rtl/wmbda_ctrl.sv @@
// ----------------------------------------------------------------------------
// wmbda_ctrl
// Frame sequencer: block collection, CRC bytes, release burst and status.
// ----------------------------------------------------------------------------
`default_nettype none

module wmbda_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic                frame_end_i,
  input  wire wmbda_pkg::dfr_sts_t sts_i,
  output wmbda_pkg::dfr_cmd_t      cmd_o
);
  import wmbda_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        pend_fend_q, pend_fend_d;
  kind_e       pend_kind_q, pend_kind_d;
  logic        in_ready;
  logic        in_fire;
  kind_e       err_kind;

  assign in_ready = (state_q != S_RELEASE) && (state_q != S_STATUS);
  assign in_fire  = in_valid_i && in_ready;
  assign err_kind = sts_i.first_blk ? KIND_ERR_FIRST : KIND_ERR_DATA;

  // next state
  always_comb begin
    state_d     = state_q;
    pend_fend_d = pend_fend_q;
    pend_kind_d = pend_kind_q;
    unique case (state_q)
      S_COLLECT: begin
        if (in_fire) begin
          if (frame_end_i) begin
            state_d     = S_STATUS;
            pend_kind_d = KIND_TRUNC;
          end else if (sts_i.blk_done) begin
            state_d = S_CRC_HI;
          end
        end
      end
      S_CRC_HI: begin
        if (in_fire) begin
          if (frame_end_i) begin
            state_d     = S_STATUS;
            pend_kind_d = KIND_TRUNC;
          end else begin
            state_d = S_CRC_LO;
          end
        end
      end
      S_CRC_LO: begin
        if (in_fire) begin
          if (sts_i.crc_ok) begin
            state_d     = S_RELEASE;
            pend_fend_d = frame_end_i;
          end else if (frame_end_i) begin
            state_d     = S_STATUS;
            pend_kind_d = err_kind;
          end else begin
            state_d = sts_i.first_blk ? S_ERR_FIRST : S_ERR_DATA;
          end
        end
      end
      S_COMPLETE: begin
        if (in_fire && frame_end_i) begin
          state_d     = S_STATUS;
          pend_kind_d = KIND_COMPLETE;
        end
      end
      S_ERR_FIRST: begin
        if (in_fire && frame_end_i) begin
          state_d     = S_STATUS;
          pend_kind_d = KIND_ERR_FIRST;
        end
      end
      S_ERR_DATA: begin
        if (in_fire && frame_end_i) begin
          state_d     = S_STATUS;
          pend_kind_d = KIND_ERR_DATA;
        end
      end
      S_RELEASE: begin
        if (sts_i.out_free && sts_i.last_rd) begin
          if (pend_fend_q) begin
            state_d     = S_STATUS;
            pend_kind_d = sts_i.total_done ? KIND_COMPLETE : KIND_EARLY;
          end else begin
            state_d = sts_i.total_done ? S_COMPLETE : S_COLLECT;
          end
        end
      end
      S_STATUS: begin
        if (sts_i.out_free) begin
          state_d = S_COLLECT;
        end
      end
      default: state_d = S_COLLECT;
    endcase
  end

  // commands
  always_comb begin
    cmd_o = '0;
    cmd_o.status_kind = pend_kind_q;
    unique case (state_q)
      S_COLLECT: cmd_o.store_byte = in_fire;
      S_CRC_HI:  cmd_o.latch_hi   = in_fire;
      S_CRC_LO:  cmd_o.accept_block = in_fire && sts_i.crc_ok;
      S_RELEASE: begin
        cmd_o.emit_data = sts_i.out_free;
        cmd_o.blk_clear = sts_i.out_free && sts_i.last_rd;
      end
      S_STATUS: begin
        cmd_o.emit_status = sts_i.out_free;
        cmd_o.frame_clear = sts_i.out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_COLLECT;
      pend_fend_q <= 1'b0;
      pend_kind_q <= KIND_TRUNC;
    end else begin
      state_q     <= state_d;
      pend_fend_q <= pend_fend_d;
      pend_kind_q <= pend_kind_d;
    end
  end

  assign in_ready_o = in_ready;

  a_no_take_while_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready |-> !(cmd_o.emit_data || cmd_o.emit_status))
    else $error("input taken during release or status");

  a_status_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit_status |=> (state_q == S_COLLECT))
    else $error("frame status not followed by a fresh frame");

  a_release_from_crc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(state_q == S_RELEASE) |-> $past(cmd_o.accept_block))
    else $error("release burst without a verified block");

endmodule

`default_nettype wire

@@ rtl/wmbus_format_a_block_crc_deframer.sv @@
// ----------------------------------------------------------------------------
// wmbus_format_a_block_crc_deframer
// Checks header and data blocks of a received frame against their CRC-16 and
// releases verified bytes, closing each frame with one status word.
// ----------------------------------------------------------------------------
// input: a data or CRC byte is taken whenever in_ready_o is high; a verified
//   block's first word is valid on the output once the sequencer has entered
//   release and the output register is loaded, then one word per cycle while
//   the output register is free; the block store has a single read port, and
//   input is held off during the release burst and the status word
// reset: rst_ni clears sequencer, counters, CRC and output valid; store is not
//   cleared
`default_nettype none

module wmbus_format_a_block_crc_deframer #(
  parameter int unsigned FIRST_BLOCK_LEN = 10,
  parameter int unsigned DATA_BLOCK_LEN  = 16
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] rx_byte_i,
  input  wire logic       frame_end_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      data_byte_o,
  output logic [2:0]      kind_o,
  output logic            last_o
);
  import wmbda_pkg::*;

  dfr_cmd_t cmd;
  dfr_sts_t sts;

  wmbda_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .frame_end_i (frame_end_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  wmbda_dp #(
    .FIRST_BLOCK_LEN (FIRST_BLOCK_LEN),
    .DATA_BLOCK_LEN  (DATA_BLOCK_LEN)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_byte_i   (rx_byte_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .data_byte_o (data_byte_o),
    .kind_o      (kind_o),
    .last_o      (last_o)
  );

endmodule

`default_nettype wire

@@ test/wmbda_deframer_checker.sv @@
// ----------------------------------------------------------------------------
// wmbda_deframer_checker
// Watches both channels of the block CRC deframer, predicts the released
// words and status of every frame, and compares each output word in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wmbda_deframer_checker #(
  parameter int unsigned HdrLen = 10,
  parameter int unsigned BlkLen = 16
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic       in_ready_i,
  input  wire logic [7:0] rx_byte_i,
  input  wire logic       frame_end_i,
  input  wire logic       out_valid_i,
  input  wire logic       out_ready_i,
  input  wire logic [7:0] data_byte_i,
  input  wire logic [2:0] kind_i,
  input  wire logic       last_i,
  output int unsigned     fail_count_o,
  output int unsigned     pending_o
);

  import wmbda_pkg::*;

  localparam int unsigned StoreLen = (HdrLen > BlkLen) ? HdrLen : BlkLen;

  typedef enum logic [2:0] {
    RX_GATHER,
    RX_CRC_HI,
    RX_CRC_LO,
    RX_DONE,
    RX_BAD_HDR,
    RX_BAD_DATA
  } rx_stage_e;

  typedef struct packed {
    logic [7:0] data;
    kind_e      kind;
    logic       last;
  } deframed_word_t;

  deframed_word_t expected_words[$];

  rx_stage_e   stage;
  logic [15:0] crc_acc;
  logic [7:0]  blk_buf [StoreLen];
  int unsigned fill;
  logic [8:0]  want_total;
  logic [8:0]  got_total;
  logic [7:0]  crc_hi;

  // bit-serial form of the msb-first crc-16
  function automatic logic [15:0] crc16_byte(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] r;
    logic        fb;
    int unsigned k;
    r = acc;
    for (k = 0; k < 8; k++) begin
      fb = r[15] ^ b[7 - k];
      r  = {r[14:0], 1'b0};
      if (fb) begin
        r = r ^ CrcPoly;
      end
    end
    return r;
  endfunction

  function automatic void restart_frame();
    stage      = RX_GATHER;
    crc_acc    = CrcInit;
    fill       = 0;
    want_total = '0;
    got_total  = '0;
    crc_hi     = '0;
  endfunction

  // header block has fixed length, data blocks shrink to what is left of L+1
  function automatic int unsigned block_goal();
    int unsigned left;
    if (got_total == 0) begin
      return HdrLen;
    end
    left = (want_total > got_total) ? int'(want_total - got_total) : 0;
    return (left > BlkLen) ? BlkLen : left;
  endfunction

  function automatic void step_deframer(input logic [7:0] b, input logic fend);
    logic [15:0] sent_crc;
    logic        hdr;
    kind_e       status;
    int unsigned i;
    case (stage)
      RX_GATHER: begin
        if (fill < StoreLen) begin
          blk_buf[fill] = b;
        end
        fill++;
        crc_acc = crc16_byte(crc_acc, b);
        if (fill >= block_goal()) begin
          stage = RX_CRC_HI;
        end
      end
      RX_CRC_HI: begin
        crc_hi = b;
        stage  = RX_CRC_LO;
      end
      RX_CRC_LO: begin
        sent_crc = {crc_hi, b};
        hdr      = (got_total == 0);
        if (sent_crc != (crc_acc ^ CrcXorOut)) begin
          stage = hdr ? RX_BAD_HDR : RX_BAD_DATA;
        end else begin
          for (i = 0; i < fill && i < StoreLen; i++) begin
            expected_words.push_back({blk_buf[i], KIND_DATA, 1'b0});
          end
          got_total = got_total + 9'(fill);
          if (hdr) begin
            want_total = {1'b0, blk_buf[0]} + 9'd1;
          end
          fill    = 0;
          crc_acc = CrcInit;
          stage   = (got_total >= want_total) ? RX_DONE : RX_GATHER;
        end
      end
      default: begin
        // done or errored: bytes are dropped until frame end
      end
    endcase

    if (fend) begin
      case (stage)
        RX_DONE:     status = KIND_COMPLETE;
        RX_BAD_HDR:  status = KIND_ERR_FIRST;
        RX_BAD_DATA: status = KIND_ERR_DATA;
        default: begin
          // clean block boundary after the header counts as ended early
          status = (stage == RX_GATHER && fill == 0 && got_total != 0) ? KIND_EARLY
                                                                        : KIND_TRUNC;
        end
      endcase
      expected_words.push_back({8'h00, status, 1'b1});
      restart_frame();
    end
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    fail_count_o++;
  endtask

  task automatic check_word();
    deframed_word_t want;
    if (expected_words.size() == 0) begin
      report_mismatch($sformatf("unexpected word data=%02h kind=%0d last=%0b",
                                data_byte_i, kind_i, last_i));
    end else begin
      want = expected_words.pop_front();
      if (data_byte_i !== want.data) begin
        report_mismatch($sformatf("data_byte %02h, want %02h", data_byte_i, want.data));
      end
      if (kind_i !== want.kind) begin
        report_mismatch($sformatf("kind %0d, want %0d", kind_i, want.kind));
      end
      if (last_i !== want.last) begin
        report_mismatch($sformatf("last %0b, want %0b", last_i, want.last));
      end
    end
  endtask

  // outputs first so a word can never match an expectation pushed this edge
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      restart_frame();
      expected_words.delete();
      fail_count_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        check_word();
      end
      if (in_valid_i && in_ready_i) begin
        step_deframer(rx_byte_i, frame_end_i);
      end
    end
    pending_o = expected_words.size();
  end

endmodule

@@ test/wmbus_format_a_block_crc_deframer_test.sv @@
// ----------------------------------------------------------------------------
// wmbus_format_a_block_crc_deframer_test
// Feeds whole and damaged frames (good, CRC errors, early ends, truncation,
// noise) through the deframer with random idling on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wmbus_format_a_block_crc_deframer_test;

  import wmbda_pkg::*;

  localparam int unsigned HdrLen   = 10;
  localparam int unsigned BlkLen   = 16;
  localparam int unsigned ItemGoal = 420;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [7:0] rx_byte_i;
  logic       frame_end_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [7:0] data_byte_o;
  logic [2:0] kind_o;
  logic       last_o;

  int unsigned fail_count;
  int unsigned pending_words;
  int unsigned bytes_sent;
  int unsigned frames_done;
  bit          calm;

  logic [7:0]  frame_q[$];
  int unsigned block_ends[$];

  wmbus_format_a_block_crc_deframer #(
    .FIRST_BLOCK_LEN(HdrLen),
    .DATA_BLOCK_LEN (BlkLen)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .rx_byte_i   (rx_byte_i),
    .frame_end_i (frame_end_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .data_byte_o (data_byte_o),
    .kind_o      (kind_o),
    .last_o      (last_o)
  );

  wmbda_deframer_checker #(
    .HdrLen(HdrLen),
    .BlkLen(BlkLen)
  ) i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .rx_byte_i    (rx_byte_i),
    .frame_end_i  (frame_end_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .data_byte_i  (data_byte_o),
    .kind_i       (kind_o),
    .last_i       (last_o),
    .fail_count_o (fail_count),
    .pending_o    (pending_words)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #10ms;
    $display("TB_ERROR");
    $finish;
  end

  // receiver: ready drops in random bursts, none once calm
  initial begin : rx_side
    int unsigned hold;
    hold        = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold != 0) begin
        out_ready_i <= 1'b0;
        hold--;
      end else begin
        out_ready_i <= 1'b1;
        if (!calm && $urandom_range(0, 13) == 0) begin
          hold = $urandom_range(1, 18);
        end
      end
    end
  end

  // frame builder crc, kept separate from the checker's predictor
  function automatic logic [15:0] next_crc(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] c;
    int unsigned k;
    c = acc ^ {b, 8'h00};
    for (k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CrcPoly) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  function automatic int unsigned pick_len();
    return ($urandom_range(0, 29) == 0) ? $urandom_range(61, 255) : $urandom_range(0, 60);
  endfunction

  // well-formed frame for length field L; block_ends holds the index after
  // each block's low crc byte
  task automatic build_frame(input int unsigned len_field, input logic fixed_pad,
                             input logic [7:0] pad_value);
    int unsigned left;
    int unsigned n;
    int unsigned k;
    logic [15:0] acc;
    logic [7:0]  b;
    frame_q.delete();
    block_ends.delete();
    acc = CrcInit;
    for (k = 0; k < HdrLen; k++) begin
      if (k == 0) begin
        b = len_field[7:0];
      end else begin
        b = fixed_pad ? pad_value : 8'($urandom_range(0, 255));
      end
      frame_q.push_back(b);
      acc = next_crc(acc, b);
    end
    acc = acc ^ CrcXorOut;
    frame_q.push_back(acc[15:8]);
    frame_q.push_back(acc[7:0]);
    block_ends.push_back(frame_q.size());
    left = (len_field + 1 > HdrLen) ? len_field + 1 - HdrLen : 0;
    while (left > 0) begin
      n   = (left > BlkLen) ? BlkLen : left;
      acc = CrcInit;
      for (k = 0; k < n; k++) begin
        b = 8'($urandom_range(0, 255));
        frame_q.push_back(b);
        acc = next_crc(acc, b);
      end
      acc = acc ^ CrcXorOut;
      frame_q.push_back(acc[15:8]);
      frame_q.push_back(acc[7:0]);
      block_ends.push_back(frame_q.size());
      left -= n;
    end
  endtask

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_byte(input logic [7:0] b, input logic fend);
    if (!calm && $urandom_range(0, 11) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    rx_byte_i   <= b;
    frame_end_i <= fend;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  // first cut bytes of the built frame, then tail random bytes, frame end on
  // whichever byte goes out last
  task automatic send_frame(input int unsigned cut, input int unsigned tail);
    int unsigned k;
    for (k = 0; k < cut; k++) begin
      send_byte(frame_q[k], tail == 0 && k == cut - 1);
    end
    for (k = 0; k < tail; k++) begin
      send_byte(8'($urandom_range(0, 255)), k == tail - 1);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_words != 0) @(negedge clk_i);
  endtask

  task automatic run_random_frame();
    int unsigned pick;
    int unsigned len_field;
    int unsigned len;
    int unsigned k;
    int unsigned pos;
    int unsigned n;
    pick = $urandom_range(0, 99);
    if (pick < 90) begin
      len_field = pick_len();
      // data crc errors and early ends need at least one data block
      if (pick >= 55 && pick < 75 && len_field < HdrLen) begin
        len_field = $urandom_range(HdrLen, 60);
      end
      build_frame(len_field, 1'b0, 8'h00);
      len = frame_q.size();
      if (pick < 45) begin
        // good frame, sometimes with bytes trailing after completion
        send_frame(len, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
      end else if (pick < 55) begin
        pos = $urandom_range(0, HdrLen + 1);
        frame_q[pos] ^= 8'h01 << $urandom_range(0, 7);
        send_frame($urandom_range(HdrLen + 2, len), $urandom_range(0, 2));
      end else if (pick < 65) begin
        k   = $urandom_range(1, block_ends.size() - 1);
        pos = $urandom_range(block_ends[k - 1], block_ends[k] - 1);
        frame_q[pos] ^= 8'h01 << $urandom_range(0, 7);
        send_frame($urandom_range(block_ends[k], len), $urandom_range(0, 2));
      end else if (pick < 75) begin
        send_frame(block_ends[$urandom_range(0, block_ends.size() - 2)], 0);
      end else begin
        send_frame($urandom_range(1, len - 1), 0);
      end
    end else begin
      // noise, with stray frame ends
      n = $urandom_range(1, 24);
      for (k = 0; k < n; k++) begin
        send_byte(8'($urandom_range(0, 255)), k == n - 1 || $urandom_range(0, 11) == 0);
      end
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    rx_byte_i   = 8'h00;
    frame_end_i = 1'b0;
    calm        = 1'b0;
    bytes_sent  = 0;
    frames_done = 0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // frame end on the very first byte
    send_byte(8'hFF, 1'b1);
    // short header, L+1 below the header length
    build_frame(0, 1'b1, 8'hFF);
    send_frame(frame_q.size(), 0);
    // header crc error, frame ends on the bad crc byte
    build_frame(HdrLen - 1, 1'b1, 8'h00);
    frame_q[HdrLen + 1] ^= 8'h80;
    send_frame(frame_q.size(), 0);
    wait_drained();

    while (bytes_sent < ItemGoal) begin
      if (bytes_sent >= ItemGoal - 80) begin
        calm = 1'b1;
      end
      run_random_frame();
      frames_done++;
      if (frames_done % 7 == 0) begin
        wait_drained();
      end
    end

    in_valid_i  <= 1'b0;
    frame_end_i <= 1'b0;
    while (pending_words != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    if (fail_count == 0 && pending_words == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ wmbus_format_a_block_crc_deframer.f @@
rtl/wmbda_pkg.sv
rtl/wmbda_dp.sv
rtl/wmbda_ctrl.sv
rtl/wmbus_format_a_block_crc_deframer.sv
test/wmbda_deframer_checker.sv
test/wmbus_format_a_block_crc_deframer_test.sv
